FILE: rtl/core/kli_pkg.sv
package kli_pkg;

   // Key table geometry
   localparam int MAX_KEYS  = 64;
   localparam int KEY_IDX_W = $clog2(MAX_KEYS);
   localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

   // Interpolation unit
   localparam int NUM_COMPS = 3;
   localparam int COMP_W    = 2;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_INTERP = 2'd0;
   localparam logic [1:0] STATUS_HOLD   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic              accept;
      logic              read_first;
      logic              read_next;
      logic              load_left;
      logic              advance;
      logic              take_right;
      logic              hold;
      logic              prep;
      logic              mul;
      logic              add;
      logic              div_step;
      logic              acc;
      logic [COMP_W-1:0] comp;
      logic              publish;
   } kli_ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_query;
      logic count_zero;
      logic has_next;
      logic has_next2;
      logic advance_ok;
      logic left_ge;
      logic out_free;
   } kli_stat_type;

endpackage

FILE: rtl/core/kli_if.sv
interface kli_req_if;
   import kli_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [31:0]        time_ticks;
   logic signed [31:0] val_x;
   logic signed [31:0] val_y;
   logic signed [31:0] val_z;

   modport source (output valid, output cmd, output time_ticks, output val_x,
                   output val_y, output val_z, input ready);
   modport sink   (input valid, input cmd, input time_ticks, input val_x,
                   input val_y, input val_z, output ready);
endinterface

interface kli_rsp_if;
   import kli_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [1:0]         status;
   logic               keys_dropped;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output status, output keys_dropped, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input status, input keys_dropped, output ready);
endinterface

FILE: rtl/core/kli_ctrl.sv
module kli_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kli_pkg::kli_stat_type stat,
   output kli_pkg::kli_ctrl_type ctrl
);
   import kli_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_SCAN = 4'd2;
   localparam logic [3:0] ST_HOLD = 4'd3;
   localparam logic [3:0] ST_PREP = 4'd4;
   localparam logic [3:0] ST_MUL  = 4'd5;
   localparam logic [3:0] ST_ADD  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_ACC  = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [COMP_W-1:0]    comp_ff, comp_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence a query through search, interpolation or hold, result
   always_comb begin
      state_in  = state_ff;
      comp_in   = comp_ff;
      step_in   = step_ff;
      ctrl      = '0;
      ctrl.comp = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               if (stat.is_query) begin
                  if (stat.count_zero) begin
                     state_in = ST_DONE;
                  end else begin
                     ctrl.read_first = 1'b1;
                     state_in        = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            ctrl.load_left = 1'b1;
            if (stat.has_next) begin
               ctrl.read_next = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_SCAN: begin
            if (stat.advance_ok) begin
               ctrl.advance = 1'b1;
               if (stat.has_next2) begin
                  ctrl.read_next = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end else begin
               ctrl.take_right = 1'b1;
               if (stat.left_ge) begin
                  state_in = ST_HOLD;
               end else begin
                  comp_in  = '0;
                  state_in = ST_PREP;
               end
            end
         end
         ST_HOLD: begin
            ctrl.hold = 1'b1;
            state_in  = ST_DONE;
         end
         ST_PREP: begin
            ctrl.prep = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            ctrl.add = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            ctrl.acc = 1'b1;
            if (comp_ff == COMP_W'(NUM_COMPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               ctrl.publish = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: rtl/core/kli_dpath.sv
module kli_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  kli_pkg::kli_ctrl_type ctrl,
   output kli_pkg::kli_stat_type stat,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_time_ticks,
   input  logic signed [31:0]    req_val_x,
   input  logic signed [31:0]    req_val_y,
   input  logic signed [31:0]    req_val_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_out_x,
   output logic signed [31:0]    rsp_out_y,
   output logic signed [31:0]    rsp_out_z,
   output logic [1:0]            rsp_status,
   output logic                  rsp_keys_dropped
);
   import kli_pkg::*;

   typedef struct packed {
      logic [31:0]        time_ticks;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } key_entry_type;

   // Key table
   key_entry_type mem [MAX_KEYS];
   key_entry_type rd_ff;

   logic [KEY_CNT_W-1:0] count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic [KEY_IDX_W-1:0] left_ff, left_in;
   logic [31:0]          t_ff, t_in;
   logic [31:0]          tl_ff, tl_in;
   logic signed [31:0]   lv_ff [NUM_COMPS];
   logic signed [31:0]   lv_in [NUM_COMPS];
   logic signed [31:0]   rv_ff [NUM_COMPS];
   logic signed [31:0]   rv_in [NUM_COMPS];
   logic signed [31:0]   res_ff [NUM_COMPS];
   logic signed [31:0]   res_in [NUM_COMPS];
   logic [1:0]           res_status_ff, res_status_in;
   logic [31:0]          n_ff, n_in;
   logic [31:0]          g_ff, g_in;
   logic [31:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          prod_ff, prod_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_x_ff, rsp_x_in;
   logic signed [31:0]   rsp_y_ff, rsp_y_in;
   logic signed [31:0]   rsp_z_ff, rsp_z_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_drop_ff, rsp_drop_in;

   logic                 full;
   logic                 wr_en;
   logic                 rd_en;
   logic [KEY_CNT_W-1:0] left_p1;
   logic [KEY_CNT_W-1:0] left_p2;
   logic [KEY_IDX_W-1:0] rd_addr;
   key_entry_type        wr_entry;
   logic signed [32:0]   diff;
   logic [64:0]          num;
   logic [32:0]          trial;
   logic                 qbit;

   assign full    = (count_ff >= KEY_CNT_W'(MAX_KEYS));
   assign wr_en   = ctrl.accept && (req_cmd == CMD_APPEND) && !full;
   assign left_p1 = KEY_CNT_W'(left_ff) + KEY_CNT_W'(1);
   assign left_p2 = KEY_CNT_W'(left_ff) + KEY_CNT_W'(2);
   assign rd_en   = ctrl.read_first || ctrl.read_next;

   // Pick the next entry to read: first key, or the one past the new left key
   always_comb begin
      if (ctrl.read_first) begin
         rd_addr = '0;
      end else if (ctrl.advance) begin
         rd_addr = left_p2[KEY_IDX_W-1:0];
      end else begin
         rd_addr = left_p1[KEY_IDX_W-1:0];
      end
   end

   assign wr_entry.time_ticks = req_time_ticks;
   assign wr_entry.x          = req_val_x;
   assign wr_entry.y          = req_val_y;
   assign wr_entry.z          = req_val_z;

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[KEY_IDX_W-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Status back to the controller
   assign stat.is_query   = (req_cmd == CMD_QUERY);
   assign stat.count_zero = (count_ff == '0);
   assign stat.has_next   = (left_p1 < count_ff);
   assign stat.has_next2  = (left_p2 < count_ff);
   assign stat.advance_ok = (rd_ff.time_ticks <= t_ff);
   assign stat.left_ge    = (tl_ff >= t_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Component difference, long-division step
   assign diff  = {rv_ff[ctrl.comp][31], rv_ff[ctrl.comp]}
                - {lv_ff[ctrl.comp][31], lv_ff[ctrl.comp]};
   assign num   = {1'b0, prod_ff} + 65'(g_ff >> 1);
   assign trial = {rem_ff, quo_ff[31]};
   assign qbit  = (trial >= {1'b0, g_ff});

   always_comb begin
      count_in      = count_ff;
      drop_in       = drop_ff;
      left_in       = left_ff;
      t_in          = t_ff;
      tl_in         = tl_ff;
      lv_in         = lv_ff;
      rv_in         = rv_ff;
      res_in        = res_ff;
      res_status_in = res_status_ff;
      n_in          = n_ff;
      g_in          = g_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_status_in = rsp_status_ff;
      rsp_drop_in   = rsp_drop_ff;

      // Take a new item
      if (ctrl.accept) begin
         case (req_cmd)
            CMD_CLEAR: begin
               count_in = '0;
               drop_in  = 1'b0;
            end
            CMD_APPEND: begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_QUERY: begin
               t_in          = req_time_ticks;
               left_in       = '0;
               res_in[0]     = '0;
               res_in[1]     = '0;
               res_in[2]     = '0;
               res_status_in = STATUS_EMPTY;
            end
            default: begin
            end
         endcase
      end

      // Capture the left key, stepping forward while scanning
      if (ctrl.load_left || ctrl.advance) begin
         tl_in    = rd_ff.time_ticks;
         lv_in[0] = rd_ff.x;
         lv_in[1] = rd_ff.y;
         lv_in[2] = rd_ff.z;
      end
      if (ctrl.advance) begin
         left_in = left_p1[KEY_IDX_W-1:0];
      end

      // Capture the right key and the time gaps
      if (ctrl.take_right) begin
         rv_in[0] = rd_ff.x;
         rv_in[1] = rd_ff.y;
         rv_in[2] = rd_ff.z;
         g_in     = rd_ff.time_ticks - tl_ff;
         n_in     = t_ff - tl_ff;
      end

      // Hold the left key value
      if (ctrl.hold) begin
         res_in        = lv_ff;
         res_status_in = STATUS_HOLD;
      end

      // Magnitude and sign of the difference
      if (ctrl.prep) begin
         neg_in = diff[32];
         mag_in = diff[32] ? 32'(-diff) : diff[31:0];
      end

      if (ctrl.mul) begin
         prod_in = 64'(mag_ff) * 64'(n_ff);
      end

      // Add half the gap and seed the divider; quotient stays below 2^32
      if (ctrl.add) begin
         rem_in = num[63:32];
         quo_in = num[31:0];
      end

      if (ctrl.div_step) begin
         rem_in = qbit ? 32'(trial - {1'b0, g_ff}) : trial[31:0];
         quo_in = {quo_ff[30:0], qbit};
      end

      // Apply the rounded step toward the right key
      if (ctrl.acc) begin
         res_in[ctrl.comp] = neg_ff ? lv_ff[ctrl.comp] - $signed(quo_ff)
                                    : lv_ff[ctrl.comp] + $signed(quo_ff);
         res_status_in     = STATUS_INTERP;
      end

      // Output register
      if (ctrl.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_x_in      = res_ff[0];
         rsp_y_in      = res_ff[1];
         rsp_z_in      = res_ff[2];
         rsp_status_in = res_status_ff;
         rsp_drop_in   = drop_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      left_ff       <= left_in;
      t_ff          <= t_in;
      tl_ff         <= tl_in;
      lv_ff         <= lv_in;
      rv_ff         <= rv_in;
      res_ff        <= res_in;
      res_status_ff <= res_status_in;
      n_ff          <= n_in;
      g_ff          <= g_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_status_ff <= rsp_status_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_out_z        = rsp_z_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_keys_dropped = rsp_drop_ff;

endmodule

FILE: rtl/core/keyframe_linear_interpolator.sv
// Clear and append items leave the controller idle; the next item is accepted in the following cycle.
// Empty-table query: accepted, then published as zero values with empty status.
// Held key: the search loads the first key, steps over keys, then holds the left key value.
// Interpolating query: one shared multiplier and a 32-step divider run per axis.
// One item is worked on at a time; the next is accepted once the result is in the output register.
// Sync reset empties the table, clears the drop flag and output valid; key RAM keeps its contents.
module keyframe_linear_interpolator (
   input  logic      clock,
   input  logic      reset,
   kli_req_if.sink   req_if,
   kli_rsp_if.source rsp_if
);
   import kli_pkg::*;

   kli_ctrl_type ctrl;
   kli_stat_type stat;
   logic         ready;

   kli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   kli_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_cmd          (req_if.cmd),
      .req_time_ticks   (req_if.time_ticks),
      .req_val_x        (req_if.val_x),
      .req_val_y        (req_if.val_y),
      .req_val_z        (req_if.val_z),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_out_x        (rsp_if.out_x),
      .rsp_out_y        (rsp_if.out_y),
      .rsp_out_z        (rsp_if.out_z),
      .rsp_status       (rsp_if.status),
      .rsp_keys_dropped (rsp_if.keys_dropped)
   );

   assign req_if.ready = ready;

   // A result never overwrites one that is still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.publish |-> stat.out_free)
      else $error("result published over a pending item");

   // Output valid comes up only after a publish command
   a_valid_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(ctrl.publish))
      else $error("output valid without publish");

   // Empty-table results carry zero values
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == STATUS_EMPTY) |->
         (rsp_if.out_x == '0 && rsp_if.out_y == '0 && rsp_if.out_z == '0))
      else $error("empty-table result with nonzero value");

   // No item is taken while a query loads its left key
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (ctrl.read_first || ctrl.load_left || ctrl.advance || ctrl.div_step) |->
         !(ctrl.load_left && ctrl.accept))
      else $error("item accepted during search");

endmodule
